// ===== src/kmed_pkg.sv =====
// ----------------------------------------------------------------------------
// kmed_pkg
// Shared types, constants and the matrix-to-key map of the key matrix
// event detector.
// ----------------------------------------------------------------------------
package kmed_pkg;

    localparam int KEY_COUNT  = 18;
    localparam int ROW_COUNT  = 3;
    localparam int COL_COUNT  = 6;
    localparam int KEY_W      = 5;
    localparam int LEVEL_W    = 6;
    localparam int ROW_CNT_W  = 3;    // pressed keys in one row, 0..6
    localparam int HELD_W     = 5;    // pressed keys in one scan, 0..18
    localparam int ROW_IDX_W  = 2;

    localparam logic [HELD_W-1:0] MAX_HELD_RESET = HELD_W'(2);

    localparam logic [ROW_IDX_W-1:0] ROW_1 = 2'd0;
    localparam logic [ROW_IDX_W-1:0] ROW_2 = 2'd1;
    localparam logic [ROW_IDX_W-1:0] ROW_3 = 2'd2;

    // Logical key for each row and column (column 1 first)
    localparam logic [KEY_W-1:0] KEY_MAP [ROW_COUNT][COL_COUNT] = '{
        '{5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd3},
        '{5'd2,  5'd8,  5'd6,  5'd10, 5'd1,  5'd0},
        '{5'd4,  5'd5,  5'd7,  5'd9,  5'd11, 5'd12}
    };

    typedef logic [KEY_COUNT-1:0] key_vec_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] row1_levels;
        logic [LEVEL_W-1:0] row2_levels;
        logic [LEVEL_W-1:0] row3_levels;
    } kmed_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             event_kind;
        logic             last_event;
    } kmed_out_t;

    // What one row lane found
    typedef struct packed {
        key_vec_t             key_bits;
        logic [ROW_CNT_W-1:0] held_count;
    } kmed_lane_t;

    // Merged scan handed to the event emitter
    typedef struct packed {
        key_vec_t event_mask;
        key_vec_t now_keys;
    } kmed_scan_t;

endpackage

// ===== src/kmed_row_lane.sv =====
// ----------------------------------------------------------------------------
// kmed_row_lane
// Decodes the active-low column levels of one driven row into logical key
// bits and counts the keys pressed in that row.
// ----------------------------------------------------------------------------
module kmed_row_lane
    import kmed_pkg::*;
(
    input  logic [ROW_IDX_W-1:0] row_sel,
    input  logic [LEVEL_W-1:0]   levels,
    output kmed_lane_t           lane
);

    // Place each pressed column on its logical key and count it
    always_comb begin
        lane = '0;
        for (int c = 0; c < COL_COUNT; c++) begin
            if (!levels[c]) begin
                lane.key_bits[KEY_MAP[row_sel][c]] = 1'b1;
                lane.held_count = lane.held_count + ROW_CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/kmed_merge.sv =====
// ----------------------------------------------------------------------------
// kmed_merge
// Combines the three row lanes, applies the held-key limit and keeps the
// key states of the previous scan.
// ----------------------------------------------------------------------------
module kmed_merge
    import kmed_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [HELD_W-1:0] cfg_wr_data,
    input  logic              scan_accept,
    input  kmed_lane_t        lane_1,
    input  kmed_lane_t        lane_2,
    input  kmed_lane_t        lane_3,
    output kmed_scan_t        scan
);

    key_vec_t          prev_pressed_reg;
    key_vec_t          prev_pressed_next;
    logic [HELD_W-1:0] max_held_reg;
    logic [HELD_W-1:0] max_held_next;
    logic [HELD_W-1:0] held_total;
    logic              suppress;

    // Merge lanes and decide whether this scan reports
    always_comb begin
        scan.now_keys = lane_1.key_bits | lane_2.key_bits | lane_3.key_bits;
        held_total    = HELD_W'(lane_1.held_count) + HELD_W'(lane_2.held_count)
                      + HELD_W'(lane_3.held_count);
        suppress      = held_total > max_held_reg;
        scan.event_mask = suppress ? '0 : (scan.now_keys ^ prev_pressed_reg);
    end

    // Take the new key states on every accepted scan; take limit writes
    always_comb begin
        prev_pressed_next = scan_accept ? scan.now_keys : prev_pressed_reg;
        max_held_next     = cfg_wr_en ? cfg_wr_data : max_held_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pressed_reg <= '0;
            max_held_reg     <= MAX_HELD_RESET;
        end else begin
            prev_pressed_reg <= prev_pressed_next;
            max_held_reg     <= max_held_next;
        end
    end

endmodule

// ===== src/kmed_event_emit.sv =====
// ----------------------------------------------------------------------------
// kmed_event_emit
// Holds the changed keys of one scan and hands them out in ascending key
// order, one per cycle unless stalled, via an output register; marks the last.
// ----------------------------------------------------------------------------
module kmed_event_emit
    import kmed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       scan_accept,
    input  kmed_scan_t scan,
    output logic       idle,
    output logic       m_valid,
    input  logic       m_ready,
    output kmed_out_t  m_data
);

    key_vec_t   pending_reg;
    key_vec_t   pending_next;
    key_vec_t   level_reg;
    key_vec_t   level_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    kmed_out_t  m_data_reg;
    kmed_out_t  m_data_next;
    key_vec_t   low_bit;
    key_vec_t   rest;
    logic [KEY_W-1:0] low_index;
    logic       out_free;

    assign idle    = (pending_reg == '0);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Pick the lowest pending key
    always_comb begin
        low_bit   = pending_reg & (~pending_reg + key_vec_t'(1));
        rest      = pending_reg & ~low_bit;
        low_index = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (pending_reg[k]) begin
                low_index = KEY_W'(k);
            end
        end
    end

    // Advance the event queue and load the output register; a new scan is
    // only taken while the queue is empty, so both never act together
    always_comb begin
        pending_next = pending_reg;
        level_next   = level_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            if (pending_reg != '0) begin
                m_valid_next           = 1'b1;
                m_data_next.key_index  = low_index;
                m_data_next.event_kind = level_reg[low_index];
                m_data_next.last_event = (rest == '0);
                pending_next           = rest;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (scan_accept) begin
            pending_next = scan.event_mask;
            level_next   = scan.now_keys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        m_data_reg <= m_data_next;
    end

    // Each emitted event removes exactly one pending key
    a_one_per_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!scan_accept && out_free && pending_reg != '0) |=>
            ($countones(pending_reg) == $countones($past(pending_reg)) - 1))
        else $error("pending keys not reduced by one per event");

    // Only valid keys are reported
    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.key_index < KEY_W'(KEY_COUNT)))
        else $error("event key index out of range");

    // A non-final event means the rest of its scan is still queued
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last_event) |-> (pending_reg != '0))
        else $error("event not marked last but nothing left to emit");

endmodule

// ===== src/key_matrix_event_detector.sv =====
// ----------------------------------------------------------------------------
// key_matrix_event_detector
// Turns full scans of a 3 x 6 key matrix into press and release events,
// one per changed key, in ascending key order.
//
//   Port group   Handshake          Payload
//   s_*          s_valid/s_ready    kmed_in_t  (three rows of column levels)
//   m_*          m_valid/m_ready    kmed_out_t (key, kind, last marker)
//   cfg_*        cfg_wr_en          max_held_keys, 5 bits
//
// Three row lanes decode a scan and the merge stage compares it with the
// stored key states in the cycle it is accepted.
// A scan with N changed keys leaves as N events (none past the held-key
// limit), one per cycle while m_ready allows, from the single event
// emitter; s_ready returns once the final event is loaded into the
// output register. A stall on m_ready holds that register and the queue.
// Reset: all keys released, max_held_keys = 2, no event pending.
// ----------------------------------------------------------------------------
module key_matrix_event_detector
    import kmed_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kmed_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kmed_out_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [HELD_W-1:0] cfg_wr_data
);

    kmed_lane_t lane_1;
    kmed_lane_t lane_2;
    kmed_lane_t lane_3;
    kmed_scan_t scan;
    logic       emit_idle;
    logic       scan_accept;

    // Take a new scan only once the previous one is fully queued out
    assign s_ready     = emit_idle;
    assign scan_accept = s_valid && s_ready;

    kmed_row_lane u_lane_1 (
        .row_sel (ROW_1),
        .levels  (s_data.row1_levels),
        .lane    (lane_1)
    );

    kmed_row_lane u_lane_2 (
        .row_sel (ROW_2),
        .levels  (s_data.row2_levels),
        .lane    (lane_2)
    );

    kmed_row_lane u_lane_3 (
        .row_sel (ROW_3),
        .levels  (s_data.row3_levels),
        .lane    (lane_3)
    );

    kmed_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .scan_accept (scan_accept),
        .lane_1      (lane_1),
        .lane_2      (lane_2),
        .lane_3      (lane_3),
        .scan        (scan)
    );

    kmed_event_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scan_accept (scan_accept),
        .scan        (scan),
        .idle        (emit_idle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
